// ----- hw/rtl/tick_task_slot_scheduler_macros.svh -----
// Assertion macros shared by the assertions of the scheduler checker
`ifndef TICK_TASK_SLOT_SCHEDULER_MACROS_SVH
`define TICK_TASK_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TTS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TTS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tts_pkg.sv -----
// Shared types, codes and defaults for the tick task slot scheduler
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

	localparam int unsigned NUM_SLOTS_DEF  = 8;
	localparam int unsigned DELAY_BITS_DEF = 16;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_TICK     = 1'b1;

	typedef enum logic [1:0] {
		KIND_REG  = 2'd0,
		KIND_FIRE = 2'd1,
		KIND_IDLE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TAKEN = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		kind_t      kind;
		status_t    status;
		logic [2:0] fired_slot;
		logic       last;
	} res_t;

	typedef struct packed {
		logic vld;
		res_t res;
	} push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tts_mem.sv -----
// Slot table memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module tts_mem #(
	parameter int unsigned DEPTH = tts_pkg::NUM_SLOTS_DEF,
	parameter int unsigned WIDTH = 2 * tts_pkg::DELAY_BITS_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] ram_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= ram_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tts_ctrl.sv -----
// Sequencer: registration, slot walk with read-modify-write, result ordering
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl #(
	parameter int unsigned NUM_SLOTS  = tts_pkg::NUM_SLOTS_DEF,
	parameter int unsigned DELAY_BITS = tts_pkg::DELAY_BITS_DEF,
	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int unsigned ENT_W = 2 * DELAY_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              req_type,
	input  wire logic [7:0]        slot,
	input  wire logic [15:0]       first_delay,
	input  wire logic [15:0]       period,
	input  wire logic              start_ready,
	input  wire logic              out_free,
	output tts_pkg::push_t         push,
	output logic                   mem_we,
	output logic      [IDX_W-1:0]  mem_waddr,
	output logic      [ENT_W-1:0]  mem_wdata,
	output logic                   mem_re,
	output logic      [IDX_W-1:0]  mem_raddr,
	input  wire logic [ENT_W-1:0]  mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                 state_q, state_d;
	logic [NUM_SLOTS-1:0]   used_q, rdy_q;
	logic                   pend_vld_q;
	logic [IDX_W-1:0]       pend_q;
	logic [IDX_W-1:0]       idx_s1;
	tts_pkg::kind_t         fin_kind_q;
	tts_pkg::status_t       fin_status_q;

	logic                   accept;
	logic                   in_rng;
	logic [IDX_W-1:0]       reg_idx;
	tts_pkg::status_t       reg_status;
	logic [DELAY_BITS-1:0]  dly, per, per_fix;
	logic [DELAY_BITS-1:0]  cnt, rper, cnt_nxt;
	logic                   active, fire, stall, is_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign in_rng  = slot < 8'(NUM_SLOTS);
	assign reg_idx = slot[IDX_W-1:0];

	always_comb begin
		priority if (!in_rng) begin
			reg_status = tts_pkg::ST_RANGE;
		end else if (used_q[reg_idx]) begin
			reg_status = tts_pkg::ST_TAKEN;
		end else begin
			reg_status = tts_pkg::ST_OK;
		end
	end

	assign dly     = DELAY_BITS'(first_delay);
	assign per     = DELAY_BITS'(period);
	assign per_fix = (per == '0) ? DELAY_BITS'(1) : per;

	assign cnt     = mem_rdata[ENT_W-1:DELAY_BITS];
	assign rper    = mem_rdata[DELAY_BITS-1:0];
	assign active  = used_q[idx_s1] && rdy_q[idx_s1];
	assign fire    = active && (cnt == '0);
	// hold the walk when an earlier fire event cannot be handed to the output
	assign stall   = fire && pend_vld_q && !out_free;
	assign is_last = (idx_s1 == IDX_W'(NUM_SLOTS - 1));
	// reload before decrement, so a zero countdown never wraps
	assign cnt_nxt = (fire ? rper : cnt) - DELAY_BITS'(1);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = {cnt_nxt, rper};
		mem_re    = 1'b0;
		mem_raddr = idx_s1;
		push.vld  = 1'b0;
		push.res  = '{kind: tts_pkg::KIND_FIRE, status: tts_pkg::ST_OK,
			fired_slot: 3'(pend_q), last: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == tts_pkg::REQ_TICK) begin
						mem_re    = 1'b1;
						mem_raddr = '0;
						state_d   = S_WALK;
					end else begin
						state_d = S_FIN;
						if (reg_status == tts_pkg::ST_OK) begin
							mem_we    = 1'b1;
							mem_waddr = reg_idx;
							mem_wdata = {dly, per_fix};
						end
					end
				end
			end
			S_WALK: begin
				// on a stall re-read the same slot; nothing was written to it
				mem_re = 1'b1;
				if (!stall) begin
					mem_we   = active;
					push.vld = fire && pend_vld_q;
					if (is_last) begin
						state_d = S_FIN;
					end else begin
						mem_raddr = idx_s1 + 1'b1;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					push.vld = 1'b1;
					push.res = '{kind: fin_kind_q, status: fin_status_q,
						fired_slot: 3'(pend_q), last: 1'b1};
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			rdy_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_vld_q <= 1'b0;
				if (req_type == tts_pkg::REQ_REGISTER && reg_status == tts_pkg::ST_OK) begin
					used_q[reg_idx] <= 1'b1;
					rdy_q[reg_idx]  <= start_ready;
				end
			end else if (state_q == S_WALK && !stall && fire) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= '0;
			pend_q <= '0;
			if (req_type == tts_pkg::REQ_TICK) begin
				fin_kind_q   <= tts_pkg::KIND_IDLE;
				fin_status_q <= tts_pkg::ST_OK;
			end else begin
				fin_kind_q   <= tts_pkg::KIND_REG;
				fin_status_q <= reg_status;
			end
		end else if (state_q == S_WALK && !stall) begin
			if (fire) begin
				pend_q <= idx_s1;
			end
			if (!is_last) begin
				idx_s1 <= idx_s1 + 1'b1;
			end else if (fire || pend_vld_q) begin
				fin_kind_q <= tts_pkg::KIND_FIRE;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tick_task_slot_scheduler.sv -----
// Top level of the tick task slot scheduler
//
//  channel | valid / ready         | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | req_type, slot, first_delay, period, start_ready
//  out     | out_valid / out_ready | kind, status, fired_slot, last
//
// A register item updates the slot in the transfer cycle; S_FIN then loads the
// status result. A tick walks one slot a cycle, unless a stall holds the walk,
// through the single read port of the slot memory, then loads the final result.
// A stalled output holds the walk only when a second fire event must be handed on.
// Reset clears all slots at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_slot_scheduler #(
	parameter int unsigned NUM_SLOTS  = tts_pkg::NUM_SLOTS_DEF,
	parameter int unsigned DELAY_BITS = tts_pkg::DELAY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [7:0]  slot,
	input  wire logic [15:0] first_delay,
	input  wire logic [15:0] period,
	input  wire logic        start_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  kind,
	output logic      [1:0]  status,
	output logic      [2:0]  fired_slot,
	output logic             last
);

	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned ENT_W = 2 * DELAY_BITS;

	tts_pkg::push_t    push;
	tts_pkg::res_t     out_res_q;
	logic              out_vld_q;
	logic              out_free;
	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [ENT_W-1:0]  mem_wdata, mem_rdata;

	assign out_free = !out_vld_q || out_ready;

	tts_ctrl #(
		.NUM_SLOTS  (NUM_SLOTS),
		.DELAY_BITS (DELAY_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.slot        (slot),
		.first_delay (first_delay),
		.period      (period),
		.start_ready (start_ready),
		.out_free    (out_free),
		.push        (push),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	tts_mem #(
		.DEPTH (NUM_SLOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.vld) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld) begin
			out_res_q <= push.res;
		end
	end

	assign out_valid  = out_vld_q;
	assign kind       = out_res_q.kind;
	assign status     = out_res_q.status;
	assign fired_slot = out_res_q.fired_slot;
	assign last       = out_res_q.last;

endmodule

`default_nettype wire

// ----- hw/rtl/tts_chk.sv -----
// Port-level checker for the tick task slot scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "tick_task_slot_scheduler_macros.svh"

module tts_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        req_type,
	input wire logic [7:0]  slot,
	input wire logic [15:0] first_delay,
	input wire logic [15:0] period,
	input wire logic        start_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [1:0]  status,
	input wire logic [2:0]  fired_slot,
	input wire logic        last
);

	// a waiting request keeps its valid and payload until the transfer
	`TTS_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready,
		in_valid && $stable(req_type) && $stable(slot) && $stable(first_delay)
		&& $stable(period) && $stable(start_ready), "waiting request changed")

	`TTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(status) && $stable(fired_slot)
		&& $stable(last), "stalled result changed")

	`TTS_ASSERT_IMP(a_single_last, clk, arst_n, out_valid && kind != tts_pkg::KIND_FIRE,
		last, "status or idle result without last mark")

	`TTS_ASSERT_IMP(a_slot_zero, clk, arst_n, out_valid && kind != tts_pkg::KIND_FIRE,
		fired_slot == 3'd0, "fired_slot set outside a fire event")

	`TTS_ASSERT_IMP(a_status_zero, clk, arst_n, out_valid && kind != tts_pkg::KIND_REG,
		status == tts_pkg::ST_OK, "status set outside a registration result")

endmodule

bind tick_task_slot_scheduler tts_chk u_chk (.*);

`default_nettype wire
